// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PTT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("periodic timer table check failed");

// next-cycle implication
`define PTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("periodic timer table sequence check failed");

`endif

// ===== hdl/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic timer table package
// Request, result and slot types, command codes and fixed constants.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int ID_W    = 8;
  localparam int TIME_W  = 24;
  localparam int IDLE_W  = 16;
  localparam int COUNT_W = 5;

  localparam logic [TIME_W-1:0] SENTINEL_WAIT = TIME_W'(1000000);
  localparam logic [IDLE_W-1:0] IDLE_RESET    = IDLE_W'(60);

  typedef enum logic [1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_CHANGE     = 2'd1,
    CMD_UNREGISTER = 2'd2,
    CMD_ELAPSED    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_FETCH,
    ST_LOAD
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ID_W-1:0]   client_id;
    logic [TIME_W-1:0] period_seconds;
    logic [TIME_W-1:0] elapsed_seconds;
  } in_req_t;

  typedef struct packed {
    logic              fired_valid;
    logic [ID_W-1:0]   fired_id;
    logic [TIME_W-1:0] next_wait_seconds;
    logic              table_full;
    logic [COUNT_W-1:0] slot_count;
    logic              last;
  } out_res_t;

  typedef struct packed {
    logic [ID_W-1:0]   client;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] remaining;
  } slot_t;

endpackage

// ===== hdl/ptt_slot_ram.sv =====
// ----------------------------------------------------------------------------
// Slot memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptt_slot_ram #(
  parameter int SLOTS = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] waddr,
  input  ptt_pkg::slot_t                         wdata,
  input  logic                                   re,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] raddr,
  output ptt_pkg::slot_t                         rdata
);

  ptt_pkg::slot_t mem [SLOTS];
  ptt_pkg::slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ptt_fire_buf.sv =====
// ----------------------------------------------------------------------------
// Fired id buffer
// Holds client ids of fired slots in table order until they are reported.
// ----------------------------------------------------------------------------
module ptt_fire_buf #(
  parameter int SLOTS = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] waddr,
  input  logic [ptt_pkg::ID_W-1:0]               wdata,
  input  logic                                   re,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] raddr,
  output logic [ptt_pkg::ID_W-1:0]               rdata
);

  logic [ptt_pkg::ID_W-1:0] mem [SLOTS];
  logic [ptt_pkg::ID_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ptt_engine.sv =====
// ----------------------------------------------------------------------------
// Timer table engine
// Sequencer that sweeps the slot memory once per request, updates entries,
// tracks the soonest slot and reports one result per fired slot, or a single one if none fired.
// ----------------------------------------------------------------------------
module ptt_engine #(
  parameter int SLOTS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_accept,
  input  ptt_pkg::in_req_t                       in_req,
  output logic                                   in_stall,
  input  logic [ptt_pkg::IDLE_W-1:0]             idle_wait,
  input  logic                                   out_free,
  output logic                                   res_load,
  output ptt_pkg::out_res_t                      res,
  output logic                                   slot_we,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot_waddr,
  output ptt_pkg::slot_t                         slot_wdata,
  output logic                                   slot_re,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot_raddr,
  input  ptt_pkg::slot_t                         slot_rdata,
  output logic                                   fire_we,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] fire_waddr,
  output logic [ptt_pkg::ID_W-1:0]               fire_wdata,
  output logic                                   fire_re,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] fire_raddr,
  input  logic [ptt_pkg::ID_W-1:0]               fire_rdata
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int TW = ptt_pkg::TIME_W;

  ptt_pkg::state_t           state_r, state_nxt;
  ptt_pkg::cmd_t             cmd_r, cmd_nxt;
  logic [ptt_pkg::ID_W-1:0]  id_r, id_nxt;
  logic [TW-1:0]             period_r, period_nxt;
  logic [TW-1:0]             elapsed_r, elapsed_nxt;
  logic                      full_r, full_nxt;
  logic [CW-1:0]             used_r, used_nxt;
  logic [CW-1:0]             rd_idx_r, rd_idx_nxt;
  logic                      proc_vld_r, proc_vld_nxt;
  logic [AW-1:0]             proc_idx_r, proc_idx_nxt;
  logic                      match_r, match_nxt;
  logic [TW-1:0]             min_r, min_nxt;
  logic [TW-1:0]             first_r, first_nxt;
  logic                      first_set_r, first_set_nxt;
  logic [CW-1:0]             nfire_r, nfire_nxt;
  logic [CW-1:0]             emit_idx_r, emit_idx_nxt;
  logic [TW-1:0]             wait_r, wait_nxt;

  logic                      scan_done;
  logic                      res_last;
  logic [CW-1:0]             used_fin;
  logic                      kept;
  ptt_pkg::slot_t            upd;

  assign scan_done = (rd_idx_r == used_r) && !proc_vld_r;
  assign res_last  = (nfire_r == '0) || (CW'(emit_idx_r + CW'(1)) == nfire_r);
  assign used_fin  = used_r - CW'(match_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptt_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ptt_pkg::ST_SCAN;
        end
      end
      ptt_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ptt_pkg::ST_FINISH;
        end
      end
      ptt_pkg::ST_FINISH: state_nxt = ptt_pkg::ST_FETCH;
      ptt_pkg::ST_FETCH:  state_nxt = ptt_pkg::ST_LOAD;
      ptt_pkg::ST_LOAD: begin
        if (out_free) begin
          state_nxt = res_last ? ptt_pkg::ST_IDLE : ptt_pkg::ST_FETCH;
        end
      end
      default: state_nxt = ptt_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    period_nxt    = period_r;
    elapsed_nxt   = elapsed_r;
    full_nxt      = full_r;
    used_nxt      = used_r;
    rd_idx_nxt    = rd_idx_r;
    proc_vld_nxt  = 1'b0;
    proc_idx_nxt  = proc_idx_r;
    match_nxt     = match_r;
    min_nxt       = min_r;
    first_nxt     = first_r;
    first_set_nxt = first_set_r;
    nfire_nxt     = nfire_r;
    emit_idx_nxt  = emit_idx_r;
    wait_nxt      = wait_r;

    in_stall   = (state_r != ptt_pkg::ST_IDLE);
    res_load   = 1'b0;
    res        = '0;
    slot_we    = 1'b0;
    slot_waddr = proc_idx_r;
    slot_wdata = slot_rdata;
    slot_re    = 1'b0;
    slot_raddr = rd_idx_r[AW-1:0];
    fire_we    = 1'b0;
    fire_waddr = nfire_r[AW-1:0];
    fire_wdata = slot_rdata.client;
    fire_re    = 1'b0;
    fire_raddr = emit_idx_r[AW-1:0];
    kept       = 1'b1;
    upd        = slot_rdata;

    case (state_r)
      ptt_pkg::ST_IDLE: begin
        if (in_accept) begin
          cmd_nxt       = in_req.cmd;
          id_nxt        = in_req.client_id;
          period_nxt    = in_req.period_seconds;
          elapsed_nxt   = in_req.elapsed_seconds;
          full_nxt      = (in_req.cmd == ptt_pkg::CMD_REGISTER) && (used_r == CW'(SLOTS));
          rd_idx_nxt    = '0;
          match_nxt     = 1'b0;
          min_nxt       = ptt_pkg::SENTINEL_WAIT;
          first_set_nxt = 1'b0;
          nfire_nxt     = '0;
          emit_idx_nxt  = '0;
          // append
          if ((in_req.cmd == ptt_pkg::CMD_REGISTER) && (used_r != CW'(SLOTS))) begin
            slot_we    = 1'b1;
            slot_waddr = used_r[AW-1:0];
            slot_wdata = '{client: in_req.client_id, period: in_req.period_seconds,
                           remaining: in_req.period_seconds};
            used_nxt   = used_r + CW'(1);
          end
        end
      end
      ptt_pkg::ST_SCAN: begin
        if (rd_idx_r != used_r) begin
          slot_re      = 1'b1;
          rd_idx_nxt   = rd_idx_r + CW'(1);
          proc_vld_nxt = 1'b1;
          proc_idx_nxt = rd_idx_r[AW-1:0];
        end
        if (proc_vld_r) begin
          case (cmd_r)
            ptt_pkg::CMD_CHANGE: begin
              if (slot_rdata.client == id_r) begin
                upd.period    = period_r;
                upd.remaining = period_r;
                slot_we       = 1'b1;
              end
            end
            ptt_pkg::CMD_UNREGISTER: begin
              if (!match_r && (slot_rdata.client == id_r)) begin
                kept      = 1'b0;
                match_nxt = 1'b1;
              end else if (match_r) begin
                // close the gap
                slot_we    = 1'b1;
                slot_waddr = proc_idx_r - AW'(1);
              end
            end
            ptt_pkg::CMD_ELAPSED: begin
              slot_we = 1'b1;
              if (slot_rdata.remaining <= elapsed_r) begin
                fire_we       = 1'b1;
                nfire_nxt     = nfire_r + CW'(1);
                upd.remaining = slot_rdata.period;
              end else begin
                upd.remaining = slot_rdata.remaining - elapsed_r;
              end
            end
            default: begin
            end
          endcase
          slot_wdata = upd;
          if (kept) begin
            if (upd.remaining < min_r) begin
              min_nxt = upd.remaining;
            end
            if (!first_set_r) begin
              first_nxt     = upd.remaining;
              first_set_nxt = 1'b1;
            end
          end
        end
      end
      ptt_pkg::ST_FINISH: begin
        used_nxt = used_fin;
        if (used_fin == '0) begin
          wait_nxt = TW'(idle_wait);
        end else if (min_r < ptt_pkg::SENTINEL_WAIT) begin
          wait_nxt = min_r;
        end else begin
          wait_nxt = first_r;
        end
      end
      ptt_pkg::ST_FETCH: begin
        fire_re = (nfire_r != '0);
      end
      ptt_pkg::ST_LOAD: begin
        if (out_free) begin
          res_load              = 1'b1;
          res.fired_valid       = (nfire_r != '0);
          res.fired_id          = (nfire_r != '0) ? fire_rdata : '0;
          res.next_wait_seconds = wait_r;
          res.table_full        = full_r;
          res.slot_count        = ptt_pkg::COUNT_W'(used_r);
          res.last              = res_last;
          emit_idx_nxt          = emit_idx_r + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ptt_pkg::ST_IDLE;
      used_r     <= '0;
      proc_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      proc_vld_r <= proc_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    id_r        <= id_nxt;
    period_r    <= period_nxt;
    elapsed_r   <= elapsed_nxt;
    full_r      <= full_nxt;
    rd_idx_r    <= rd_idx_nxt;
    proc_idx_r  <= proc_idx_nxt;
    match_r     <= match_nxt;
    min_r       <= min_nxt;
    first_r     <= first_nxt;
    first_set_r <= first_set_nxt;
    nfire_r     <= nfire_nxt;
    emit_idx_r  <= emit_idx_nxt;
    wait_r      <= wait_nxt;
  end

endmodule

// ===== hdl/periodic_timer_table.sv =====
// ----------------------------------------------------------------------------
// Periodic timer table
// Ordered table of periodic timer slots with register, change period,
// unregister and elapsed-time requests; reports fired clients and next wait.
//
//   channel   direction  handshake             payload
//   in_       request    in_valid / in_stall   in_req  (ptt_pkg::in_req_t)
//   out_      result     out_valid / out_stall out_res (ptt_pkg::out_res_t)
//   cfg_      write      cfg_we                cfg_wdata (idle wait)
//
// A request sweeps the N slots in use through the slot memory (one read port,
// one entry per cycle), then reads the R fired ids back from the fired id
// buffer, loading one result for each (a single result when none fired).
// One request is in flight at a time; in_stall is high until its last result
// is loaded into the output register.
// A full output register held by out_stall does not block the next request.
// Synchronous active-low reset empties the table and sets the idle wait to 60.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module periodic_timer_table #(
  parameter int SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ptt_pkg::in_req_t              in_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ptt_pkg::out_res_t             out_res,
  input  logic                          cfg_we,
  input  logic [ptt_pkg::IDLE_W-1:0]    cfg_wdata
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [ptt_pkg::IDLE_W-1:0] idle_wait_r;
  logic                       out_valid_r;
  ptt_pkg::out_res_t          out_res_r;

  logic                       in_accept;
  logic                       out_free;
  logic                       res_load;
  ptt_pkg::out_res_t          res;

  logic                       slot_we;
  logic [AW-1:0]              slot_waddr;
  ptt_pkg::slot_t             slot_wdata;
  logic                       slot_re;
  logic [AW-1:0]              slot_raddr;
  ptt_pkg::slot_t             slot_rdata;

  logic                       fire_we;
  logic [AW-1:0]              fire_waddr;
  logic [ptt_pkg::ID_W-1:0]   fire_wdata;
  logic                       fire_re;
  logic [AW-1:0]              fire_raddr;
  logic [ptt_pkg::ID_W-1:0]   fire_rdata;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  ptt_engine #(
    .SLOTS (SLOTS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_req     (in_req),
    .in_stall   (in_stall),
    .idle_wait  (idle_wait_r),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res),
    .slot_we    (slot_we),
    .slot_waddr (slot_waddr),
    .slot_wdata (slot_wdata),
    .slot_re    (slot_re),
    .slot_raddr (slot_raddr),
    .slot_rdata (slot_rdata),
    .fire_we    (fire_we),
    .fire_waddr (fire_waddr),
    .fire_wdata (fire_wdata),
    .fire_re    (fire_re),
    .fire_raddr (fire_raddr),
    .fire_rdata (fire_rdata)
  );

  ptt_slot_ram #(
    .SLOTS (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  ptt_fire_buf #(
    .SLOTS (SLOTS)
  ) u_fire_buf (
    .clk   (clk),
    .we    (fire_we),
    .waddr (fire_waddr),
    .wdata (fire_wdata),
    .re    (fire_re),
    .raddr (fire_raddr),
    .rdata (fire_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_wait_r <= ptt_pkg::IDLE_RESET;
    end else if (cfg_we) begin
      idle_wait_r <= cfg_wdata;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `PTT_ASSERT_NEXT(a_busy_after_request, in_accept, in_stall)
  `PTT_ASSERT_NOW(a_full_single_result, out_valid_r && out_res_r.table_full, !out_res_r.fired_valid && out_res_r.last)
  `PTT_ASSERT_NOW(a_quiet_id, out_valid_r && !out_res_r.fired_valid, (out_res_r.fired_id == '0) && out_res_r.last)
  `PTT_ASSERT_NOW(a_count_bound, out_valid_r, (SLOTS > 31) || (int'(out_res_r.slot_count) <= SLOTS))

endmodule
